### sv/dht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dht_pkg;
  localparam int TableSlots = 223;
  localparam int SlotBits = 8;
  localparam int KeyBits = 16;
  localparam int PayloadBits = 16;
  localparam int StatusBits = 3;
  localparam int StepBase = 7;

  typedef logic [SlotBits-1:0] slot_idx_t;
  typedef logic [KeyBits-1:0] key_t;
  typedef logic [PayloadBits-1:0] payload_t;

  typedef enum logic [0:0] {
    FUNC_INSERT = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  typedef enum logic [StatusBits-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Classified request handed from front to back.
  typedef struct packed {
    func_t     func;
    key_t      key;
    payload_t  payload;
    slot_idx_t home;
    logic [2:0] step;
  } req_t;

  typedef struct packed {
    status_t   status;
    slot_idx_t slot;
    payload_t  found_payload;
  } resp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_OUT
  } bk_state_t;
endpackage
`default_nettype wire

### sv/dht_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Accepts requests, computes home slot and probe step, queues them (2 deep).
module dht_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dht_pkg::func_t   in_func,
  input  wire dht_pkg::key_t    in_key,
  input  wire dht_pkg::payload_t in_payload,
  output logic                q_valid,
  input  wire logic           q_ready,
  output dht_pkg::req_t       q_req
);
  dht_pkg::req_t q_mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  dht_pkg::req_t req_new;
  logic          push, pop;

  // mod 223 via small combinational fold: 16-bit key = hi*256+lo, 256 = 223+33
  logic [15:0] k;
  logic [14:0] f1;   // hi*33 + lo, <= 8670
  logic [13:0] f2;   // fold again
  logic [8:0]  f3;
  logic [7:0]  home;
  logic [2:0]  m7;
  logic [16:0] s7;

  always_comb begin
    k    = in_key;
    f1   = 15'(k[15:8]) * 15'd33 + 15'(k[7:0]);
    f2   = 14'(f1[14:8]) * 14'd33 + 14'(f1[7:0]);
    f3   = 9'(f2[13:8]) * 9'd33 + 9'(f2[7:0]);
    // f3 < 511: subtract 223 up to twice
    if (f3 >= 9'd446)      home = 8'(f3 - 9'd446);
    else if (f3 >= 9'd223) home = 8'(f3 - 9'd223);
    else                   home = f3[7:0];
    // mod 7: 8 == 1 mod 7, sum octal digits
    s7 = 17'(k[2:0]) + 17'(k[5:3]) + 17'(k[8:6]) + 17'(k[11:9]) + 17'(k[14:12])
       + 17'(k[15]);
    s7 = 17'(s7[2:0]) + 17'(s7[5:3]);
    s7 = 17'(s7[2:0]) + 17'(s7[5:3]);
    m7 = (s7[2:0] == 3'd7) ? 3'd0 : s7[2:0];
    req_new.func    = in_func;
    req_new.key     = in_key;
    req_new.payload = in_payload;
    req_new.home    = home;
    req_new.step    = 3'(dht_pkg::StepBase) - m7;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_req    = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= req_new;
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

### sv/dht_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Walks the probe path, one memory read per probe, writes on insert.
module dht_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire dht_pkg::req_t q_req,
  output logic               out_valid,
  input  wire logic          out_ready,
  output dht_pkg::resp_t     out_resp
);
  logic [dht_pkg::TableSlots-1:0] valid_r;
  dht_pkg::key_t     key_mem [dht_pkg::TableSlots];
  dht_pkg::payload_t pay_mem [dht_pkg::TableSlots];

  dht_pkg::bk_state_t state_r, state_nxt;
  dht_pkg::req_t      req_r, req_nxt;
  dht_pkg::slot_idx_t idx_r, idx_nxt;
  logic [8:0]         n_r, n_nxt;
  dht_pkg::resp_t     resp_r, resp_nxt;
  dht_pkg::key_t      rd_key_r;
  dht_pkg::payload_t  rd_pay_r;
  logic               rd_vld_r;
  logic               wr_en;
  logic [8:0]         idx_sum;

  always_ff @(posedge clk) begin
    rd_key_r <= key_mem[idx_r];
    rd_pay_r <= pay_mem[idx_r];
    rd_vld_r <= valid_r[idx_r];
    if (wr_en) begin
      key_mem[idx_r] <= req_r.key;
      pay_mem[idx_r] <= req_r.payload;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
    resp_r <= resp_nxt;
    if (!rst_n) begin
      state_r <= dht_pkg::BK_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) valid_r[idx_r] <= 1'b1;
    end
  end

  assign idx_sum = 9'(idx_r) + 9'(req_r.step);

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    resp_nxt  = resp_r;
    q_ready   = 1'b0;
    wr_en     = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      dht_pkg::BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          req_nxt   = q_req;
          idx_nxt   = q_req.home;
          n_nxt     = '0;
          state_nxt = dht_pkg::BK_READ;
        end
      end
      dht_pkg::BK_READ: state_nxt = dht_pkg::BK_CHECK;
      dht_pkg::BK_CHECK: begin
        state_nxt = dht_pkg::BK_OUT;
        resp_nxt  = '{dht_pkg::ST_FULL, '0, '0};
        if (!rd_vld_r) begin
          if (req_r.func == dht_pkg::FUNC_INSERT) begin
            wr_en    = 1'b1;
            resp_nxt = '{dht_pkg::ST_INSERTED, idx_r, '0};
          end else begin
            resp_nxt = '{dht_pkg::ST_NOT_FOUND, '0, '0};
          end
        end else if (rd_key_r == req_r.key) begin
          if (req_r.func == dht_pkg::FUNC_INSERT)
            resp_nxt = '{dht_pkg::ST_DUPLICATE, idx_r, '0};
          else
            resp_nxt = '{dht_pkg::ST_FOUND, idx_r, rd_pay_r};
        end else if (n_r != 9'(dht_pkg::TableSlots - 1)) begin
          n_nxt     = n_r + 9'd1;
          idx_nxt   = (idx_sum >= 9'(dht_pkg::TableSlots))
                    ? 8'(idx_sum - 9'(dht_pkg::TableSlots)) : idx_sum[7:0];
          state_nxt = dht_pkg::BK_READ;
        end
      end
      dht_pkg::BK_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = dht_pkg::BK_IDLE;
      end
      default: state_nxt = dht_pkg::BK_IDLE;
    endcase
  end

  assign out_resp = resp_r;
endmodule
`default_nettype wire

### sv/double_hash_table_insert_lookup.sv
// Double-hashing hash table, 223 slots, insert and lookup.
// Input stream: in_* transfers carry func (tuser), key and payload (tdata).
// Output stream: out_* transfers carry status, slot, found_payload.
// One result per input transfer, in order.
// A front stage computes home slot (key mod 223) and step (7 - key mod 7)
// and holds up to two requests in a small queue; the back stage walks the
// probe path with one registered memory read per probe.
// Each item is written into the front queue, taken in the back stage's IDLE
// state, passes its READ and CHECK states once per probe and is shown in OUT.
// The back stage takes a new item only once the last result has been taken.
// A full probe path takes 223 probes and returns table full.
// Reset clears every slot's valid bit at once; no clearing pass is needed.
// When the receiver stalls, the result is held and the back stage waits;
// the front keeps taking transfers until its queue fills.
`timescale 1ns / 1ps
`default_nettype none
module double_hash_table_insert_lookup (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // key[15:0], payload[31:16]
  input  wire logic        in_tuser,   // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // status[2:0], slot[10:3], found_payload[26:11]
);
  logic            q_valid, q_ready;
  dht_pkg::req_t   q_req;
  dht_pkg::resp_t  resp;

  dht_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_func    (dht_pkg::func_t'(in_tuser)),
    .in_key     (in_tdata[15:0]),
    .in_payload (in_tdata[31:16]),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_req      (q_req)
  );

  dht_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_resp  (resp)
  );

  assign out_tdata = {5'd0, resp.found_payload, resp.slot, resp.status};
endmodule
`default_nettype wire
